// File: rtl/mexp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mexp_pkg;

    // Configuration register indexes
    localparam logic CFG_MODULUS  = 1'b0;
    localparam logic CFG_EXPONENT = 1'b1;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_COMMIT,
        ST_DONE
    } state_t;

    // Per-cycle control shared by every cell of a chain
    typedef struct packed {
        logic clr;
        logic en;
        logic b_bit;
    } cell_ctrl_t;

    // Reduction choice fed back to every cell
    typedef struct packed {
        logic ge1;
        logic ge2;
    } cell_sel_t;

endpackage

`default_nettype wire

// File: rtl/modular_exponentiation.sv
`timescale 1ns / 1ps
`default_nettype none
// One item at a time: in_ready rises in the same cycle as out_valid, and each item runs
// a reduction pass plus one pass per exponent bit up to its highest set bit (none for a
// zero exponent), each a run of two bit-serial multiplier cell chains (product and square
// side by side) followed by a commit state.
// Reset: rst_n asynchronous, active low; modulus resets to 2, exponent to 1, block idles.

module modular_exponentiation #(
    parameter int WIDTH = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic               cfg_index,
    input  wire logic [WIDTH-1:0]   cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [WIDTH-1:0]   message,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [WIDTH-1:0]        power_result
);

    localparam int CNW = $clog2(WIDTH);

    mexp_pkg::state_t state_reg, state_next;
    logic             pre_reg, pre_next;
    logic [CNW-1:0]   cnt_reg, cnt_next;
    logic [WIDTH-1:0] e_reg, e_next;
    logic [WIDTH-1:0] acc_reg, acc_next;
    logic [WIDTH-1:0] base_reg, base_next;
    logic [WIDTH-1:0] bsh_reg, bsh_next;
    logic [WIDTH-1:0] modulus_reg;
    logic [WIDTH-1:0] exponent_reg;
    logic             out_valid_reg, out_valid_next;
    logic [WIDTH-1:0] power_result_reg, power_result_next;

    logic             in_fire;
    logic             last_bit;
    logic             out_free;
    logic [WIDTH-1:0] e_shift;
    logic [WIDTH-1:0] sq_a;
    logic [WIDTH-1:0] p_prod;
    logic [WIDTH-1:0] s_prod;
    mexp_pkg::cell_ctrl_t ctrl;

    assign in_fire  = in_valid & in_ready;
    assign last_bit = (cnt_reg == CNW'(WIDTH - 1));
    assign out_free = ~out_valid_reg | out_ready;
    assign e_shift  = pre_reg ? e_reg : (e_reg >> 1);
    // First pass reduces the message as 1 * message
    assign sq_a     = pre_reg ? WIDTH'(1) : base_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg  <= WIDTH'(2);
            exponent_reg <= WIDTH'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mexp_pkg::CFG_MODULUS:  modulus_reg  <= cfg_data;
                mexp_pkg::CFG_EXPONENT: exponent_reg <= cfg_data;
                default:                ;
            endcase
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mexp_pkg::ST_IDLE:
                if (in_fire)
                    state_next = mexp_pkg::ST_MUL;
            mexp_pkg::ST_MUL:
                if (last_bit)
                    state_next = mexp_pkg::ST_COMMIT;
            mexp_pkg::ST_COMMIT:
                state_next = (e_shift == '0) ? mexp_pkg::ST_DONE : mexp_pkg::ST_MUL;
            mexp_pkg::ST_DONE:
                if (out_free)
                    state_next = mexp_pkg::ST_IDLE;
            default:
                state_next = mexp_pkg::ST_IDLE;
        endcase
    end

    // Outputs and datapath
    always_comb
    begin
        in_ready          = 1'b0;
        ctrl              = '0;
        ctrl.b_bit        = bsh_reg[WIDTH-1];
        pre_next          = pre_reg;
        cnt_next          = cnt_reg;
        e_next            = e_reg;
        acc_next          = acc_reg;
        base_next         = base_reg;
        bsh_next          = bsh_reg;
        out_valid_next    = out_valid_reg & ~out_ready;
        power_result_next = power_result_reg;
        unique case (state_reg)
            mexp_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_fire)
                begin
                    ctrl.clr  = 1'b1;
                    pre_next  = 1'b1;
                    cnt_next  = '0;
                    e_next    = exponent_reg;
                    acc_next  = WIDTH'(1);
                    base_next = message;
                    bsh_next  = message;
                end
            end
            mexp_pkg::ST_MUL:
            begin
                ctrl.en  = 1'b1;
                bsh_next = bsh_reg << 1;
                cnt_next = cnt_reg + CNW'(1);
            end
            mexp_pkg::ST_COMMIT:
            begin
                ctrl.clr  = 1'b1;
                cnt_next  = '0;
                pre_next  = 1'b0;
                if (!pre_reg && e_reg[0])
                    acc_next = p_prod;
                base_next = s_prod;
                bsh_next  = s_prod;
                e_next    = e_shift;
            end
            mexp_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    power_result_next = acc_reg;
                end
            end
            default:
                ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mexp_pkg::ST_IDLE;
            pre_reg       <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pre_reg       <= pre_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        e_reg            <= e_next;
        acc_reg          <= acc_next;
        base_reg         <= base_next;
        bsh_reg          <= bsh_next;
        power_result_reg <= power_result_next;
    end

    // Product chain: acc * base
    mexp_chain #(.WIDTH(WIDTH)) u_prod (
        .clk  (clk),
        .ctrl (ctrl),
        .a    (acc_reg),
        .n    (modulus_reg),
        .prod (p_prod)
    );

    // Square chain: base * base (1 * message in the reduction pass)
    mexp_chain #(.WIDTH(WIDTH)) u_square (
        .clk  (clk),
        .ctrl (ctrl),
        .a    (sq_a),
        .n    (modulus_reg),
        .prod (s_prod)
    );

    assign out_valid    = out_valid_reg;
    assign power_result = power_result_reg;

    // An accepted item always starts with the reduction pass
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == mexp_pkg::ST_MUL) && pre_reg)
        else $error("accepted item did not start the reduction pass");

    // Exponent passes run only while exponent bits remain
    a_ebits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mexp_pkg::ST_COMMIT && !pre_reg) |-> (e_reg != '0))
        else $error("multiply pass with an exhausted exponent");

    // A pass reaches the commit state only after its last bit count
    a_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mexp_pkg::ST_COMMIT) |-> ($past(cnt_reg) == CNW'(WIDTH - 1)))
        else $error("multiply pass ended early");

    // A finished item lands in the free output register
    a_deliver: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mexp_pkg::ST_DONE && out_free) |=> out_valid_reg)
        else $error("finished item not presented");

endmodule

`default_nettype wire

// File: rtl/mexp_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module mexp_cell (
    input  wire logic                   clk,
    input  wire mexp_pkg::cell_ctrl_t   ctrl,
    input  wire mexp_pkg::cell_sel_t    sel,
    input  wire logic                   keep,
    input  wire logic                   a_bit,
    input  wire logic                   sh_bit,
    input  wire logic                   n_bit,
    input  wire logic                   n2_bit,
    input  wire logic                   c_in,
    input  wire logic                   bw1_in,
    input  wire logic                   bw2_in,
    output logic                        c_out,
    output logic                        bw1_out,
    output logic                        bw2_out,
    output logic                        acc_q
);

    logic acc_reg;
    logic acc_next;
    logic addend;
    logic s;
    logic d1;
    logic d2;

    // Form one bit of 2*acc + b*a, then of that sum minus n and minus 2n
    always_comb
    begin
        addend  = a_bit & ctrl.b_bit;
        s       = sh_bit ^ addend ^ c_in;
        c_out   = (sh_bit & addend) | (sh_bit & c_in) | (addend & c_in);
        d1      = s ^ n_bit ^ bw1_in;
        bw1_out = (~s & n_bit) | (~(s ^ n_bit) & bw1_in);
        d2      = s ^ n2_bit ^ bw2_in;
        bw2_out = (~s & n2_bit) | (~(s ^ n2_bit) & bw2_in);
    end

    // Clear, hold or pick the reduced bit
    always_comb
    begin
        if (ctrl.clr)
            acc_next = 1'b0;
        else if (ctrl.en)
        begin
            if (sel.ge2)
                acc_next = d2 & keep;
            else if (sel.ge1)
                acc_next = d1 & keep;
            else
                acc_next = s & keep;
        end
        else
            acc_next = acc_reg;
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign acc_q = acc_reg;

endmodule

`default_nettype wire

// File: rtl/mexp_chain.sv
`timescale 1ns / 1ps
`default_nettype none

module mexp_chain #(
    parameter int WIDTH = 32
) (
    input  wire logic                   clk,
    input  wire mexp_pkg::cell_ctrl_t   ctrl,
    input  wire logic [WIDTH-1:0]       a,
    input  wire logic [WIDTH-1:0]       n,
    output logic [WIDTH-1:0]            prod
);

    localparam int CW = WIDTH + 2;

    logic [CW-1:0] a_ext;
    logic [CW-1:0] n_ext;
    logic [CW-1:0] n2_ext;
    logic [CW-1:0] acc_q;
    logic [CW-1:0] sh_ext;
    logic [CW:0]   c;
    logic [CW:0]   bw1;
    logic [CW:0]   bw2;
    logic          n_zero;
    mexp_pkg::cell_sel_t sel;

    assign a_ext  = {2'b00, a};
    assign n_ext  = {2'b00, n};
    assign n2_ext = {1'b0, n, 1'b0};
    assign sh_ext = {acc_q[CW-2:0], 1'b0};
    assign c[0]   = 1'b0;
    assign bw1[0] = 1'b0;
    assign bw2[0] = 1'b0;
    assign n_zero = (n == '0);

    // Subtract n or 2n where the sum reaches them; a zero modulus just wraps
    assign sel.ge1 = ~n_zero & ~bw1[CW];
    assign sel.ge2 = ~n_zero & ~bw2[CW];

    // Row of bit cells, carries and borrows ripple upward
    for (genvar i = 0; i < CW; i++)
    begin : g_cell
        mexp_cell u_cell (
            .clk     (clk),
            .ctrl    (ctrl),
            .sel     (sel),
            .keep    (i < WIDTH),
            .a_bit   (a_ext[i]),
            .sh_bit  (sh_ext[i]),
            .n_bit   (n_ext[i]),
            .n2_bit  (n2_ext[i]),
            .c_in    (c[i]),
            .bw1_in  (bw1[i]),
            .bw2_in  (bw2[i]),
            .c_out   (c[i+1]),
            .bw1_out (bw1[i+1]),
            .bw2_out (bw2[i+1]),
            .acc_q   (acc_q[i])
        );
    end

    assign prod = acc_q[WIDTH-1:0];

endmodule

`default_nettype wire
